FILE: rtl/core/dnjd_pkg.sv
// Package for the day-number to Julian-calendar date converter.
// Holds the divisor, offsets and small constant tables shared by the RTL
// and the checker. Depends on nothing.
`default_nettype none

package dnjd_pkg;

	// Days in four Julian years. C is the floor of (4B - 489) / DIVISOR.
	localparam int unsigned DIV_W     = 11;
	localparam logic [DIV_W:0] DIVISOR = 12'd1461;

	// Cycles from the accepting edge to the edge that ends the done cycle.
	localparam int unsigned PIPE_LATENCY = 5;

	// 4 * (day_number + 1524) - 489 = 4 * day_number + JDN_BIAS
	localparam int unsigned JDN_BIAS = 5607;

	// Only the low nine bits of B and D matter, since B - D lies in 123..488.
	localparam int unsigned OFS_W = 9;
	localparam logic [OFS_W-1:0] B_OFFSET_LO = 9'(1524);

	localparam logic [3:0]  MONTH_WRAP_E = 4'd14;
	localparam logic [3:0]  MONTH_MARCH  = 4'd3;
	localparam logic [15:0] YEAR_BIAS_LATE  = 16'd4716;
	localparam logic [15:0] YEAR_BIAS_EARLY = 16'd4715;

	// Entry k-1 is the smallest offset x with floor(10000x / 306001) >= k.
	localparam logic [OFS_W-1:0] E_THRESH [15] = '{
		9'd31, 9'd62, 9'd92, 9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
		9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
	};

	// Entry E is floor(306001 * E / 10000).
	localparam logic [OFS_W-1:0] E_BASE [16] = '{
		9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

	// The quotient is monotonic in x, so counting passed thresholds gives it.
	function automatic logic [3:0] e_of_offset(input logic [OFS_W-1:0] x);
		logic [3:0] e;
		e = '0;
		for (int i = 0; i < 15; i++) begin
			if (x >= E_THRESH[i]) begin
				e = e + 4'd1;
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dnjd_div_stage.sv
// Two registered stages that divide by DIVISOR through multiplication by a
// fixed reciprocal. Depends on dnjd_pkg.
`default_nettype none

module dnjd_div_stage import dnjd_pkg::*; #(
	parameter int NUM_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  logic [NUM_W-1:0] up_num,
	input  logic [OFS_W-1:0] up_b_lo,
	output logic             dn_valid,
	output logic [15:0]      dn_quo,
	output logic [OFS_W-1:0] dn_b_lo
);

	// RECIP * DIVISOR exceeds 2^SHIFT by at most DIVISOR, which is below
	// 2^(SHIFT - NUM_W), so the shifted product is the exact floor quotient.
	localparam int SHIFT   = NUM_W + DIV_W;
	localparam int RECIP_W = NUM_W + 1;
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1;
	localparam int LO_W    = (RECIP_W + 1) / 2;
	localparam int HI_W    = RECIP_W - LO_W;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
	localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];

	logic                  valid_s1;
	logic [NUM_W+LO_W-1:0] pp_lo_s1;
	logic [NUM_W+HI_W-1:0] pp_hi_s1;
	logic [OFS_W-1:0]      b_lo_s1;
	logic                  valid_s2;
	logic [15:0]           quo_s2;
	logic [OFS_W-1:0]      b_lo_s2;
	logic [PROD_W-1:0]     prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	// The reciprocal is split in two halves so each multiplier stays narrow.
	always_ff @(posedge clk) begin
		pp_lo_s1 <= (NUM_W+LO_W)'(up_num) * (NUM_W+LO_W)'(RECIP_LO);
		pp_hi_s1 <= (NUM_W+HI_W)'(up_num) * (NUM_W+HI_W)'(RECIP_HI);
		b_lo_s1  <= up_b_lo;
	end

	assign prod = PROD_W'(pp_lo_s1) + (PROD_W'(pp_hi_s1) << LO_W);

	always_ff @(posedge clk) begin
		quo_s2  <= 16'(prod >> SHIFT);
		b_lo_s2 <= b_lo_s1;
	end

	assign dn_valid = valid_s2;
	assign dn_quo   = quo_s2;
	assign dn_b_lo  = b_lo_s2;

endmodule

`default_nettype wire

FILE: rtl/core/day_number_to_julian_date.sv
// Top level of the Julian day number to Julian-calendar date converter.
// Depends on dnjd_pkg and dnjd_div_stage.
//
// Usage: raise start with a day number on day_number; the transaction is
// taken at any rising edge where start is high and busy is low. busy never
// rises, so one day number can be taken in every cycle.
// Each transaction yields one result: cal_year, cal_month and cal_day are
// shown for exactly one cycle, marked by done, in the order of the inputs.
// For any DAY_NUMBER_BITS the pipeline is the same: one stage registers the
// scaled dividend, two stages find the count of four-year cycles by
// multiplying with a fixed reciprocal of 1461 (partial products, then their
// sum), one stage finds the day offset within the year and one looks up
// month, day and year.
// Throughput is one transaction per cycle.
// Reset clears every valid bit, so no result appears until new input has
// gone through. The receiver cannot stall; results are never held back.
`default_nettype none

module day_number_to_julian_date import dnjd_pkg::*; #(
	parameter int DAY_NUMBER_BITS = 23
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DAY_NUMBER_BITS-1:0] day_number,
	output logic                       busy,
	output logic                       done,
	output logic signed [15:0]         cal_year,
	output logic [3:0]                 cal_month,
	output logic [4:0]                 cal_day
);

	localparam int NUM_W = DAY_NUMBER_BITS + 3;

	// Input stage.
	logic             valid_s1;
	logic [NUM_W-1:0] num_s1;
	logic [OFS_W-1:0] b_lo_s1;

	// Output of the divider.
	logic             valid_s3;
	logic [15:0]      c_s3;
	logic [OFS_W-1:0] b_lo_s3;

	// Stages after the divider.
	logic             valid_s4;
	logic [OFS_W-1:0] ofs_s4;
	logic [15:0]      c_s4;
	logic             valid_s5;
	logic [15:0]      year_s5;
	logic [3:0]       month_s5;
	logic [4:0]       day_s5;

	logic [2*DIV_W-1:0] d_prod;
	logic [OFS_W-1:0]   ofs;
	logic [3:0]         e_val;
	logic [3:0]         month;
	logic [OFS_W-1:0]   day_full;
	logic [15:0]        year;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= NUM_W'({day_number, 2'b00}) + NUM_W'(JDN_BIAS);
		b_lo_s1 <= day_number[OFS_W-1:0] + B_OFFSET_LO;
	end

	dnjd_div_stage #(
		.NUM_W (NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_num   (num_s1),
		.up_b_lo  (b_lo_s1),
		.dn_valid (valid_s3),
		.dn_quo   (c_s3),
		.dn_b_lo  (b_lo_s3)
	);

	// D = floor(1461 * C / 4); its low nine bits need only the low 11 bits of C.
	assign d_prod = (2*DIV_W)'(c_s3[DIV_W-1:0]) * (2*DIV_W)'(DIVISOR);
	assign ofs    = b_lo_s3 - d_prod[DIV_W-1:2];

	always_ff @(posedge clk) begin
		ofs_s4 <= ofs;
		c_s4   <= c_s3;
	end

	always_comb begin
		e_val    = e_of_offset(ofs_s4);
		day_full = ofs_s4 - E_BASE[e_val];
		if (e_val < MONTH_WRAP_E) begin
			month = e_val - 4'd1;
		end else begin
			month = e_val - 4'd13;
		end
		if (month >= MONTH_MARCH) begin
			year = c_s4 - YEAR_BIAS_LATE;
		end else begin
			year = c_s4 - YEAR_BIAS_EARLY;
		end
	end

	always_ff @(posedge clk) begin
		year_s5  <= year;
		month_s5 <= month;
		day_s5   <= day_full[4:0];
	end

	assign done      = valid_s5;
	assign cal_year  = signed'(year_s5);
	assign cal_month = month_s5;
	assign cal_day   = day_s5;

endmodule

`default_nettype wire

FILE: rtl/core/dnjd_checker.sv
// Port-level checker for the day-number to Julian-calendar date converter,
// bound to the top level at the end of this file. Depends on dnjd_pkg.
`default_nettype none

module dnjd_checker import dnjd_pkg::*; #(
	parameter int DAY_NUMBER_BITS = 23
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic [DAY_NUMBER_BITS-1:0] day_number,
	input logic                       busy,
	input logic                       done,
	input logic signed [15:0]         cal_year,
	input logic [3:0]                 cal_month,
	input logic [4:0]                 cal_day
);

	localparam int LATENCY = PIPE_LATENCY;

	// Cycles since reset was released, saturating.
	logic [4:0] up_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_cnt_q <= '0;
		end else if (up_cnt_q != '1) begin
			up_cnt_q <= up_cnt_q + 5'd1;
		end
	end

	// Every accepted transaction comes back on done, and done rises for nothing else.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(up_cnt_q) >= LATENCY) |-> (done == $past(start && !busy, LATENCY)))
		else $error("done does not match a transaction accepted LATENCY cycles earlier");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1 && cal_day <= 5'd31))
		else $error("month or day out of range");

	a_month_len: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((cal_month != 4'd4 && cal_month != 4'd6 && cal_month != 4'd9 &&
			cal_month != 4'd11) || cal_day <= 5'd30) && (cal_month != 4'd2 || cal_day <= 5'd29)))
		else $error("day beyond the length of its month");

	// Back-to-back consecutive day numbers give consecutive days of month.
	a_next_day: assert property (@(posedge clk) disable iff (!arst_n)
		((32'(up_cnt_q) >= LATENCY + 1) && done && $past(done) &&
			($past(day_number, LATENCY) ==
			DAY_NUMBER_BITS'($past(day_number, LATENCY + 1) + 1'b1)))
		|-> (cal_day == 5'd1 || cal_day == $past(cal_day) + 5'd1))
		else $error("consecutive day numbers did not give consecutive days");

endmodule

bind day_number_to_julian_date dnjd_checker #(
	.DAY_NUMBER_BITS (DAY_NUMBER_BITS)
) u_dnjd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.day_number (day_number),
	.busy       (busy),
	.done       (done),
	.cal_year   (cal_year),
	.cal_month  (cal_month),
	.cal_day    (cal_day)
);

`default_nettype wire

FILE: verif/dnjd_date_checker.sv
`timescale 1ns / 100ps
// Checker for the day-number to Julian-calendar date converter.
// Watches the input and result channels, predicts each date and compares.
// Depends on nothing but the ports of the block.

module dnjd_date_checker #(
	parameter int DAY_NUMBER_BITS = 23
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [DAY_NUMBER_BITS-1:0] day_number,
	input  logic                       done,
	input  logic signed [15:0]         cal_year,
	input  logic [3:0]                 cal_month,
	input  logic [4:0]                 cal_day,
	output int                         mismatches,
	output int                         pending
);

	typedef struct packed {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
	} julian_date_t;

	julian_date_t expected_dates[$];

	assign pending = expected_dates.size();

	// Meeus conversion with every fractional constant scaled to an exact ratio.
	function automatic julian_date_t julian_date_of(input logic [DAY_NUMBER_BITS-1:0] dn);
		longint unsigned b, c, d, e, dom, mon, yr;
		julian_date_t r;
		b = dn;
		b = b + 1524;
		c = (100 * b - 12210) / 36525;
		d = (1461 * c) / 4;
		e = (10000 * (b - d)) / 306001;
		dom = b - d - (306001 * e) / 10000;
		mon = (e < 14) ? e - 1 : e - 13;
		// A negative year wraps in the unsigned arithmetic; its low bits are two's complement.
		yr = (mon > 2) ? c - 4716 : c - 4715;
		r.year = yr[15:0];
		r.month = mon[3:0];
		r.day = dom[4:0];
		return r;
	endfunction

	initial mismatches = 0;

	always @(posedge clk) begin
		julian_date_t want;
		if (arst_n) begin
			if (start && !busy) begin
				expected_dates.push_back(julian_date_of(day_number));
			end
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result transaction with no date expected: %0d-%0d-%0d",
						cal_year, cal_month, cal_day);
					mismatches++;
				end else begin
					want = expected_dates.pop_front();
					if (cal_year !== want.year) begin
						$error("cal_year: expected %0d, got %0d", want.year, cal_year);
						mismatches++;
					end
					if (cal_month !== want.month) begin
						$error("cal_month: expected %0d, got %0d", want.month, cal_month);
						mismatches++;
					end
					if (cal_day !== want.day) begin
						$error("cal_day: expected %0d, got %0d", want.day, cal_day);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

FILE: verif/day_number_to_julian_date_test.sv
`timescale 1ns / 100ps
// Testbench top for the day-number to Julian-calendar date converter.
// Drives day numbers with random gaps; depends on dnjd_date_checker and the RTL.

module day_number_to_julian_date_test;

	localparam int DAY_NUMBER_BITS = 23;
	localparam int LATENCY = 5;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [DAY_NUMBER_BITS-1:0] DAY_MAX = '1;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [DAY_NUMBER_BITS-1:0] day_number = '0;
	logic                       busy;
	logic                       done;
	logic signed [15:0]         cal_year;
	logic [3:0]                 cal_month;
	logic [4:0]                 cal_day;
	int                         mismatches;
	int                         pending;
	int                         cycles = 0;
	bit                         gaps_on = 1'b1;

	day_number_to_julian_date #(
		.DAY_NUMBER_BITS(DAY_NUMBER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.day_number(day_number),
		.busy(busy),
		.done(done),
		.cal_year(cal_year),
		.cal_month(cal_month),
		.cal_day(cal_day)
	);

	dnjd_date_checker #(
		.DAY_NUMBER_BITS(DAY_NUMBER_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.day_number(day_number),
		.done(done),
		.cal_year(cal_year),
		.cal_month(cal_month),
		.cal_day(cal_day),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// start is lowered only ahead of a gap, so back-to-back transactions keep it high.
	task automatic send_day(input logic [DAY_NUMBER_BITS-1:0] dn);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		day_number <= dn;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [DAY_NUMBER_BITS-1:0] random_day();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return DAY_NUMBER_BITS'($urandom_range(0, int'(DAY_MAX)));
		end else if (pick < 8) begin
			// The earliest years are negative in astronomical numbering.
			return DAY_NUMBER_BITS'($urandom_range(0, 4000));
		end else begin
			return DAY_MAX - DAY_NUMBER_BITS'($urandom_range(0, 2000));
		end
	endfunction

	initial begin
		logic [DAY_NUMBER_BITS-1:0] directed[$];
		directed = '{
			23'd0, 23'd1, 23'd58, 23'd59, 23'd60, 23'd365, 23'd366, 23'd1460, 23'd1461,
			23'd1721057, 23'd1721058, 23'd1721117, 23'd1721118, 23'd1721423, 23'd1721424,
			23'd2299160, 23'd2451544, 23'd2451545,
			23'h555555, 23'h2AAAAA, 23'h3FFFFF, 23'h400000,
			DAY_MAX - 23'd1, DAY_MAX
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_day(directed[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			send_day(random_day());
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
